/* design/hkac_pkg.sv */
// ----------------------------------------------------------------------------
// hkac_pkg
// Types and constants shared by the hot key access counter.
// ----------------------------------------------------------------------------
package hkac_pkg;

  localparam int unsigned TableEntries = 64;
  localparam logic [31:0] ThresholdReset = 32'd64;

  typedef enum logic [1:0] {
    ModeRecord  = 2'd0,
    ModeQuery   = 2'd1,
    ModeCleanup = 2'd2,
    ModeClear   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
  } req_t;

  typedef struct packed {
    logic        is_hot;
    logic [31:0] access_count;
    logic [63:0] access_total;
    logic [63:0] hot_events;
    logic [63:0] distinct_keys;
    logic        table_full;
  } rsp_t;

endpackage

/* design/hot_key_access_counter_top.sv */
// Sequence: key 0 and clear go straight to the result; record/query walk every
//   entry, then re-read a hit entry's count (written back on record); cleanup walks all.
// Flow: one request in work; the next is taken only in idle, once the result is
//   taken or in the cycle that takes it.
// Reset: asynchronous; empties the table via per-entry valid flops, zeroes
//   statistics, threshold back to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
// hot_key_access_counter_top
// Per-key access counter table with threshold detection and halving decay.
// ----------------------------------------------------------------------------
module hot_key_access_counter_top #(
  parameter int unsigned TABLE_ENTRIES = hkac_pkg::TableEntries
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hkac_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hkac_pkg::rsp_t   out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IdxW:0] LastIdx = (IdxW+1)'(TABLE_ENTRIES - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;  // walk entries looking for key
  localparam logic [2:0] StRmwRd  = 3'd2;  // read count of hit entry
  localparam logic [2:0] StRmwWr  = 3'd3;
  localparam logic [2:0] StClean  = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  // configuration
  logic [31:0] thr_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? thr_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hkac_pkg::ThresholdReset;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      thr_q <= pwdata;
    end
  end

  // memories
  logic [63:0] key_mem [TABLE_ENTRIES];
  logic [31:0] cnt_mem [TABLE_ENTRIES];
  logic [63:0] key_rd_q;
  logic [31:0] cnt_rd_q;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic key_we, cnt_we;
  logic [63:0] key_wd;
  logic [31:0] cnt_wd;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= key_wd;
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
    key_rd_q <= key_mem[rd_addr];
    cnt_rd_q <= cnt_mem[rd_addr];
  end

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [2:0]  st_q, st_d;
  hkac_pkg::req_t req_q;
  logic [IdxW:0] ptr_q, ptr_d;          // address issued this cycle
  logic          rdv_q, rdv_d;          // read data belongs to rdidx_q
  logic [IdxW-1:0] rdidx_q, rdidx_d;
  logic          hit_q, hit_d;
  logic [IdxW-1:0] hidx_q, hidx_d;
  logic [63:0] tot_q, tot_d, hev_q, hev_d, uniq_q, uniq_d;
  hkac_pkg::rsp_t res_q, res_d;
  logic        ov_q, ov_d;

  // lowest free entry
  logic          free_found;
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  logic in_fire;
  assign in_ready_o  = (st_q == StIdle) && (!ov_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  logic [31:0] half;
  logic [31:0] inc;
  assign half = {1'b0, thr_q[31:1]};
  assign inc  = (cnt_rd_q == 32'hFFFF_FFFF) ? cnt_rd_q : cnt_rd_q + 32'd1;

  function automatic logic [63:0] sat64(input logic [63:0] v);
    sat64 = (v == 64'hFFFF_FFFF_FFFF_FFFF) ? v : v + 64'd1;
  endfunction

  always_comb begin
    st_d    = st_q;
    valid_d = valid_q;
    ptr_d   = ptr_q;
    rdv_d   = 1'b0;
    rdidx_d = ptr_q[IdxW-1:0];
    hit_d   = hit_q;
    hidx_d  = hidx_q;
    tot_d   = tot_q;
    hev_d   = hev_q;
    uniq_d  = uniq_q;
    res_d   = res_q;
    ov_d    = ov_q && !out_ready_i;
    rd_addr = ptr_q[IdxW-1:0];
    wr_addr = rdidx_q;
    key_we  = 1'b0;
    cnt_we  = 1'b0;
    key_wd  = req_q.key;
    cnt_wd  = cnt_rd_q;

    unique case (st_q)
      StIdle: begin
        if (in_fire) begin
          ptr_d = '0;
          hit_d = 1'b0;
          res_d = '0;
          unique case (in_data_i.mode) inside
            hkac_pkg::ModeRecord, hkac_pkg::ModeQuery: begin
              st_d = (in_data_i.key == 64'd0) ? StDone : StSearch;
              if (in_data_i.mode == hkac_pkg::ModeRecord && in_data_i.key != 64'd0)
                tot_d = sat64(tot_q);
            end
            hkac_pkg::ModeCleanup: st_d = StClean;
            default: begin
              valid_d = '0;
              tot_d   = '0;
              hev_d   = '0;
              uniq_d  = '0;
              st_d    = StDone;
            end
          endcase
        end
      end
      StSearch: begin
        // issue one read per cycle, compare the previous one
        if (ptr_q <= LastIdx) begin
          rdv_d = 1'b1;
          ptr_d = ptr_q + (IdxW+1)'(1);
        end
        if (rdv_q && valid_q[rdidx_q] && key_rd_q == req_q.key && !hit_q) begin
          hit_d  = 1'b1;
          hidx_d = rdidx_q;
        end
        if (!rdv_q && ptr_q > LastIdx) begin
          st_d = hit_q ? StRmwRd : StDone;
          if (!hit_q && req_q.mode == hkac_pkg::ModeRecord) begin
            if (free_found) begin
              valid_d[free_idx] = 1'b1;
              wr_addr = free_idx;
              key_we  = 1'b1;
              cnt_we  = 1'b1;
              cnt_wd  = 32'd1;
              uniq_d  = sat64(uniq_q);
              res_d.access_count = 32'd1;
              res_d.is_hot = (thr_q <= 32'd1);
            end else begin
              res_d.table_full = 1'b1;
            end
          end
        end
        if (hit_q || (rdv_q && valid_q[rdidx_q] && key_rd_q == req_q.key)) rd_addr = hidx_d;
      end
      StRmwRd: begin
        rd_addr = hidx_q;
        st_d = StRmwWr;
      end
      StRmwWr: begin
        if (req_q.mode == hkac_pkg::ModeRecord) begin
          wr_addr = hidx_q;
          cnt_we  = 1'b1;
          cnt_wd  = inc;
          if (inc != cnt_rd_q && inc == thr_q) hev_d = sat64(hev_q);
          res_d.access_count = inc;
          res_d.is_hot = (inc >= thr_q);
        end else begin
          res_d.access_count = cnt_rd_q;
          res_d.is_hot = (cnt_rd_q >= thr_q);
        end
        st_d = StDone;
      end
      StClean: begin
        if (ptr_q <= LastIdx) begin
          rdv_d = 1'b1;
          ptr_d = ptr_q + (IdxW+1)'(1);
        end
        // entries are distinct per cycle, so write-back never collides with read
        if (rdv_q && valid_q[rdidx_q]) begin
          if (cnt_rd_q < half) begin
            valid_d[rdidx_q] = 1'b0;
          end else begin
            cnt_we = 1'b1;
            cnt_wd = {1'b0, cnt_rd_q[31:1]};
          end
        end
        if (!rdv_q && ptr_q > LastIdx) st_d = StDone;
      end
      StDone: begin
        res_d.access_total  = tot_q;
        res_d.hot_events    = hev_q;
        res_d.distinct_keys = uniq_q;
        ov_d = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      valid_q <= '0;
      ptr_q   <= '0;
      rdv_q   <= 1'b0;
      hit_q   <= 1'b0;
      tot_q   <= '0;
      hev_q   <= '0;
      uniq_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      rdv_q   <= rdv_d;
      hit_q   <= hit_d;
      tot_q   <= tot_d;
      hev_q   <= hev_d;
      uniq_q  <= uniq_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) req_q <= in_data_i;
    rdidx_q <= rdidx_d;
    hidx_q  <= hidx_d;
    res_q   <= res_d;
  end

endmodule

/* sim/hkac_checker.sv */
// ----------------------------------------------------------------------------
// hkac_checker
// Watches the request and result channels of the hot key access counter,
// keeps its own copy of the counter table and statistics, and compares every
// result field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module hkac_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  hkac_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  hkac_pkg::rsp_t out_data_i,
  input  logic [31:0]    threshold_i,
  output int             errors_o,
  output int             pending_o
);

  localparam int unsigned N = hkac_pkg::TableEntries;

  logic        tbl_valid [N];
  logic [63:0] tbl_key   [N];
  logic [31:0] tbl_count [N];
  logic [63:0] st_total, st_hot, st_unique;
  hkac_pkg::rsp_t rsp_q [$];

  assign pending_o = rsp_q.size();

  function automatic logic [63:0] sat_inc(logic [63:0] v);
    return (v == '1) ? v : v + 64'd1;
  endfunction

  task automatic wipe_table();
    for (int i = 0; i < N; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_count[i] = '0;
    end
    st_total  = '0;
    st_hot    = '0;
    st_unique = '0;
  endtask

  task automatic count_request(input hkac_pkg::req_t r, input logic [31:0] thr);
    hkac_pkg::rsp_t p;
    int   hit;
    int   slot;
    p    = '0;
    hit  = -1;
    slot = -1;
    for (int i = N - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_key[i] == r.key) hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    case (hkac_pkg::mode_e'(r.mode))
      hkac_pkg::ModeRecord: begin
        if (r.key != '0) begin
          st_total = sat_inc(st_total);
          if (hit >= 0) begin
            if (tbl_count[hit] != '1) begin
              tbl_count[hit] = tbl_count[hit] + 32'd1;
              if (tbl_count[hit] == thr) st_hot = sat_inc(st_hot);
            end
            p.access_count = tbl_count[hit];
            p.is_hot       = tbl_count[hit] >= thr;
          end else if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot]   = r.key;
            tbl_count[slot] = 32'd1;
            st_unique       = sat_inc(st_unique);
            p.access_count  = 32'd1;
            p.is_hot        = thr <= 32'd1;
          end else begin
            p.table_full = 1'b1;
          end
        end
      end
      hkac_pkg::ModeQuery: begin
        if (r.key != '0 && hit >= 0) begin
          p.access_count = tbl_count[hit];
          p.is_hot       = tbl_count[hit] >= thr;
        end
      end
      hkac_pkg::ModeCleanup: begin
        for (int i = 0; i < N; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_count[i] < thr / 2) tbl_valid[i] = 1'b0;
            else tbl_count[i] = tbl_count[i] / 2;
          end
        end
      end
      default: wipe_table();
    endcase
    p.access_total  = st_total;
    p.hot_events    = st_hot;
    p.distinct_keys = st_unique;
    rsp_q.push_back(p);
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hkac_pkg::rsp_t e;
    if (!rst_ni) begin
      wipe_table();
      rsp_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rsp_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_data_i);
        end else begin
          e = rsp_q.pop_front();
          compare_field("is_hot", 64'(e.is_hot), 64'(out_data_i.is_hot));
          compare_field("access_count", 64'(e.access_count),
                        64'(out_data_i.access_count));
          compare_field("access_total", e.access_total, out_data_i.access_total);
          compare_field("hot_events", e.hot_events, out_data_i.hot_events);
          compare_field("distinct_keys", e.distinct_keys, out_data_i.distinct_keys);
          compare_field("table_full", 64'(e.table_full), 64'(out_data_i.table_full));
        end
      end
      if (in_valid_i && in_ready_i) count_request(in_data_i, threshold_i);
    end
  end

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives requests with bursty gaps and a stalling result side into the hot
// key access counter, with threshold changes between phases over a small key
// pool so that hits, inserts, full-table drops and decay all occur.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  hkac_pkg::req_t in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  hkac_pkg::rsp_t out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] threshold = hkac_pkg::ThresholdReset;
  int          errors;
  int          pending;
  int unsigned cycles = 0;
  logic [63:0] key_pool [16];
  int          stall_phase = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hot_key_access_counter_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o,
    .out_ready_i, .out_data_o, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready
  );

  hkac_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .threshold_i(threshold), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("hot_key_access_counter_top test failed");
      $finish;
    end
  end

  // result side: stretches of steady ready, then random stalls
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 100) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_threshold(input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    threshold <= v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send(input hkac_pkg::mode_e m, input logic [63:0] k);
    in_valid_i <= 1'b1;
    in_data_i  <= '{mode: m, key: k};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic lower_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    case ($urandom_range(0, 9))
      0: k = {$urandom, $urandom};
      1: k = '0;
      default: k = key_pool[$urandom_range(0, 15)];
    endcase
    return k;
  endfunction

  task automatic random_phase(input int n);
    int     burst;
    hkac_pkg::mode_e  m;
    int     r;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) m = hkac_pkg::ModeRecord;
        else if (r < 90) m = hkac_pkg::ModeQuery;
        else if (r < 98) m = hkac_pkg::ModeCleanup;
        else m = hkac_pkg::ModeClear;
        send(m, pick_key());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) begin
        lower_valid();
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
      end
    end
    lower_valid();
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
    key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    key_pool[1] = 64'd1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, each mode, key 0, insert at threshold 1
    send(hkac_pkg::ModeQuery, 64'd0);
    send(hkac_pkg::ModeRecord, 64'd0);
    send(hkac_pkg::ModeRecord, 64'hFFFF_FFFF_FFFF_FFFF);
    send(hkac_pkg::ModeRecord, 64'hFFFF_FFFF_FFFF_FFFF);
    send(hkac_pkg::ModeQuery, 64'hFFFF_FFFF_FFFF_FFFF);
    send(hkac_pkg::ModeQuery, 64'h5555_AAAA_5555_AAAA);
    send(hkac_pkg::ModeCleanup, 64'd0);
    send(hkac_pkg::ModeClear, 64'd0);
    lower_valid();
    drain();
    write_threshold(32'd1);
    send(hkac_pkg::ModeRecord, 64'd1);
    send(hkac_pkg::ModeRecord, 64'd1);
    send(hkac_pkg::ModeQuery, 64'd1);
    send(hkac_pkg::ModeCleanup, 64'hAAAA_5555_AAAA_5555);
    lower_valid();
    drain();
    // threshold 0: every tracked key hot, cleanup keeps all
    write_threshold(32'd0);
    send(hkac_pkg::ModeRecord, 64'd2);
    send(hkac_pkg::ModeCleanup, 64'd0);
    send(hkac_pkg::ModeQuery, 64'd2);
    lower_valid();
    drain();
    // fill the table past capacity
    write_threshold(32'd3);
    for (int i = 0; i < hkac_pkg::TableEntries + 2; i++)
      send(hkac_pkg::ModeRecord, 64'd100 + i);
    send(hkac_pkg::ModeRecord, 64'd100);
    send(hkac_pkg::ModeRecord, 64'd100);
    send(hkac_pkg::ModeCleanup, 64'd0);
    lower_valid();
    drain();

    write_threshold(32'hFFFF_FFFF);
    random_phase(300);
    drain();
    write_threshold(32'd4);
    random_phase(350);
    drain();
    write_threshold(32'd2);
    random_phase(250);
    drain();
    write_threshold($urandom_range(5, 40));
    random_phase(250);
    drain();

    if (errors == 0) begin
      $display("hot_key_access_counter_top test passed");
    end else begin
      $display("hot_key_access_counter_top test failed");
    end
    $finish;
  end

endmodule
